### rtl/box_mean_filter_3x3_unit_macros.svh
// assertion helpers for the box mean filter
// both sample on clk_i and stay quiet while rst_ni is low
`ifndef BOX_MEAN_FILTER_3X3_UNIT_MACROS_SVH
`define BOX_MEAN_FILTER_3X3_UNIT_MACROS_SVH

// same-cycle implication
`define BMF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bmf_pkg.sv
package bmf_pkg;

  localparam int CFG_W     = 11;  // width of a dimension register field
  localparam int DIM_W     = 14;  // holds a clamped dimension up to 8192
  localparam int POS_W     = 15;  // common width for position compares
  localparam int PIX_W     = 8;
  localparam int COL_W     = 10;  // sum of three pixels
  localparam int SUM_W     = 12;  // sum of nine pixels
  localparam int RCP_W     = 17;
  localparam int RCP_SHIFT = 16;

  // register indexes, taken from paddr[2]
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  // input kinds carried on tuser
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic emit;
    logic last;
    logic top;
    logic bot;
    logic left;
    logic right;
  } bmf_flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } bmf_result_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_W-1:0] v,
                                                 logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] ext;
    ext = DIM_W'(v);
    if (ext == '0) begin
      return DIM_W'(1);
    end else if (ext > maxv) begin
      return maxv;
    end
    return ext;
  endfunction

  // 2^16 / count, rounded up; exact floor for every sum the window can give
  function automatic logic [RCP_W-1:0] recip(logic top, logic bot, logic left,
                                             logic right);
    logic [1:0]       rows;
    logic [1:0]       cols;
    logic [3:0]       cnt;
    logic [RCP_W-1:0] m;
    rows = 2'd3 - 2'(top) - 2'(bot);
    cols = 2'd3 - 2'(left) - 2'(right);
    cnt  = 4'(rows) * 4'(cols);
    case (cnt)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd6:    m = 17'd10923;
      4'd9:    m = 17'd7282;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

### rtl/bmf_line_mem.sv
module bmf_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] line_ram [DEPTH];
  logic [DW-1:0] rdata_q;
  logic [DW-1:0] fwd_data_q;
  logic          fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      line_ram[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q    <= line_ram[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // a write to the entry being read in the same cycle wins over the old word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

### rtl/box_mean_filter_3x3_unit.sv
// the result an item causes is registered through stages 1 to 4 and then the output register
// throughput: one item per clock while the skid is empty, bounded by the single read plus write per cycle
//   on the line buffer memory; one result can wait while the next item is taken
// reset: rst_ni is asynchronous, active low; width and height read 1, position
//   and window clear, line buffer contents stay undefined until written
`include "box_mean_filter_3x3_unit_macros.svh"

module box_mean_filter_3x3_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
  input  logic        s_axis_tuser,   // [0] cmd
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] pixel_out
  output logic        m_axis_tlast,   // frame_end
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import bmf_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;  // column index
  localparam int WW = $clog2(MAX_WIDTH + 1);                      // width register
  localparam int HW = $clog2(MAX_HEIGHT + 1);                     // height register
  localparam int RW = $clog2(MAX_HEIGHT + 3);                     // row counter
  localparam int PW = SUM_W + RCP_W;                              // divide product

  // ---------------------------------------------------------------------------
  // register port: width at index 0, height at index 1, clamped on write
  // ---------------------------------------------------------------------------
  logic [WW-1:0] w_q;
  logic [HW-1:0] h_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= WW'(1);
      h_q <= HW'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_IDX_WIDTH:  w_q <= WW'(clamp_dim(pwdata[CFG_W-1:0], DIM_W'(MAX_WIDTH)));
        REG_IDX_HEIGHT: h_q <= HW'(clamp_dim(pwdata[CFG_W-1:0], DIM_W'(MAX_HEIGHT)));
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IDX_WIDTH:  prdata = 32'(w_q);
      REG_IDX_HEIGHT: prdata = 32'(h_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline advance: every stage moves together; only a full skid stops it
  // ---------------------------------------------------------------------------
  logic pipe_adv;
  logic skid_valid_q;
  logic in_acc;

  assign pipe_adv      = !skid_valid_q;
  assign s_axis_tready = pipe_adv;
  assign in_acc        = s_axis_tvalid && pipe_adv;

  // ---------------------------------------------------------------------------
  // stage 0: stream position, result decision and edge masks for the center
  // the center is one row up and one column back, or the last column two rows
  // up when the new item starts a row
  // ---------------------------------------------------------------------------
  logic [CW-1:0]    c_q, c_d;
  logic [RW-1:0]    r_q, r_d;
  logic [POS_W-1:0] c_x, r_x, w_x, h_x;
  logic             c_is0, c_is1;
  bmf_flags_t       s0_flags;
  logic [PIX_W-1:0] s0_pix;

  assign c_x   = POS_W'(c_q);
  assign r_x   = POS_W'(r_q);
  assign w_x   = POS_W'(w_q);
  assign h_x   = POS_W'(h_q);
  assign c_is0 = (c_q == '0);
  assign c_is1 = (c_x == POS_W'(1));

  always_comb begin
    s0_flags.emit = (r_x >= POS_W'(2)) || ((r_x == POS_W'(1)) && !c_is0);
    if (!c_is0) begin
      s0_flags.top   = (r_x == POS_W'(1));
      s0_flags.bot   = (r_x >= h_x);
      s0_flags.left  = c_is1;
      s0_flags.right = 1'b0;
      s0_flags.last  = 1'b0;
    end else begin
      s0_flags.top   = (r_x == POS_W'(2));
      s0_flags.bot   = (r_x >= h_x + POS_W'(1));
      s0_flags.left  = (w_x == POS_W'(1));
      s0_flags.right = 1'b1;
      s0_flags.last  = (r_x == h_x + POS_W'(1));
    end
  end

  // drain requests and anything below the image feed zeros into the lines
  assign s0_pix = ((s_axis_tuser == CMD_PIXEL) && (r_x < h_x)) ? s_axis_tdata : '0;

  always_comb begin
    c_d = c_q;
    r_d = r_q;
    if (cfg_wr) begin
      c_d = '0;
      r_d = '0;
    end else if (in_acc) begin
      if (s0_flags.emit && s0_flags.last) begin
        // final pixel of the frame: the next request opens a new frame
        c_d = '0;
        r_d = '0;
      end else if (c_x + POS_W'(1) == w_x) begin
        c_d = '0;
        if (r_x < h_x + POS_W'(2)) begin
          r_d = r_q + RW'(1);
        end
      end else begin
        c_d = c_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
      r_q <= '0;
    end else begin
      c_q <= c_d;
      r_q <= r_d;
    end
  end

  // ---------------------------------------------------------------------------
  // line buffers: one word per column, upper line in the high byte and
  // middle line in the low byte; read at accept, written back in stage 1
  // ---------------------------------------------------------------------------
  logic             s1_valid_q;
  logic [CW-1:0]    s1_addr_q;
  logic [PIX_W-1:0] s1_pix_q;
  bmf_flags_t       s1_flags_q;
  logic [15:0]      lm_rd_data;
  logic             lm_wr_en;

  assign lm_wr_en = pipe_adv && s1_valid_q;

  bmf_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (16)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (c_q),
    .wr_en_i   (lm_wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i ({lm_rd_data[7:0], s1_pix_q}),  // middle moves up, new pixel in
    .rd_data_o (lm_rd_data)
  );

  // ---------------------------------------------------------------------------
  // stage 1: shift the 3x3 window, newest column on the right
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] win_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (cfg_wr) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (lm_wr_en) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= lm_rd_data[15:8];
      win_q[1][2] <= lm_rd_data[7:0];
      win_q[2][2] <= s1_pix_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: column sums with the row masks applied
  // stage 3: total with the column masks applied, reciprocal of the count
  // stage 4: multiply by the reciprocal, keep the integer part
  // ---------------------------------------------------------------------------
  logic             s2_valid_q;
  bmf_flags_t       s2_flags_q;
  logic [COL_W-1:0] col_sum [3];
  logic             s3_valid_q;
  bmf_flags_t       s3_flags_q;
  logic [COL_W-1:0] s3_col_q [3];
  logic [SUM_W-1:0] total;
  logic             s4_valid_q;
  logic             s4_last_q;
  logic [SUM_W-1:0] s4_total_q;
  logic [RCP_W-1:0] s4_recip_q;
  logic [PW-1:0]    prod;
  bmf_result_t      new_res;
  logic             push;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      col_sum[j] = (s2_flags_q.top ? COL_W'(0) : COL_W'(win_q[0][j]))
                 + COL_W'(win_q[1][j])
                 + (s2_flags_q.bot ? COL_W'(0) : COL_W'(win_q[2][j]));
    end
  end

  assign total = (s3_flags_q.left ? SUM_W'(0) : SUM_W'(s3_col_q[0]))
               + SUM_W'(s3_col_q[1])
               + (s3_flags_q.right ? SUM_W'(0) : SUM_W'(s3_col_q[2]));

  assign prod         = PW'(s4_total_q) * PW'(s4_recip_q);
  assign new_res.pix  = prod[RCP_SHIFT +: PIX_W];
  assign new_res.last = s4_last_q;
  assign push         = pipe_adv && s4_valid_q;

  // stage payload, held while the skid is full
  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      s1_addr_q  <= c_q;
      s1_pix_q   <= s0_pix;
      s1_flags_q <= s0_flags;
      s2_flags_q <= s1_flags_q;
      s3_flags_q <= s2_flags_q;
      for (int j = 0; j < 3; j++) begin
        s3_col_q[j] <= col_sum[j];
      end
      s4_total_q <= total;
      s4_recip_q <= recip(s3_flags_q.top, s3_flags_q.bot, s3_flags_q.left,
                          s3_flags_q.right);
      s4_last_q  <= s3_flags_q.last;
    end
  end

  // requests with no result drop out after the window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (pipe_adv) begin
      s1_valid_q <= in_acc;
      s2_valid_q <= s1_valid_q && s1_flags_q.emit;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // output register plus one skid entry
  // ---------------------------------------------------------------------------
  logic        out_valid_q, out_valid_d;
  logic        skid_valid_d;
  bmf_result_t out_q, skid_q;
  logic        load_new, load_skid, skid_load;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_new     = 1'b0;
    load_skid    = 1'b0;
    skid_load    = 1'b0;
    if (out_valid_q && m_axis_tready) begin
      if (skid_valid_q) begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b0;
      end else if (push) begin
        load_new = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (!out_valid_q) begin
      if (push) begin
        load_new    = 1'b1;
        out_valid_d = 1'b1;
      end
    end else if (push) begin
      // result still waiting: park the new one
      skid_load    = 1'b1;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_new) begin
      out_q <= new_res;
    end else if (load_skid) begin
      out_q <= skid_q;
    end
    if (skid_load) begin
      skid_q <= new_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.pix;
  assign m_axis_tlast  = out_q.last;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `BMF_ASSERT_IMPL(a_col_in_range, 1'b1, c_x < w_x, "column position past image width")
  `BMF_ASSERT_IMPL(a_row_bounded, 1'b1, r_x <= h_x + POS_W'(1), "row position ran past frame")
  `BMF_ASSERT_NEXT(a_frame_restart, in_acc && s0_flags.emit && s0_flags.last, (c_q == '0) && (r_q == '0), "position not cleared after frame end")
  `BMF_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q, "skid holds a result while output is empty")
  `BMF_ASSERT_IMPL(a_count_known, s4_valid_q, s4_recip_q != '0, "neighbour count has no reciprocal")

endmodule
